>>> hdl/bfa_pkg.sv
`default_nettype none

package bfa_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // Fixed field widths of the ports
    localparam int SIZE_IN_W = 16;
    localparam int INDEX_W   = 4;
    localparam int REM_W     = 16;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        STAT_LOADED        = 2'd0,
        STAT_ALLOCATED     = 2'd1,
        STAT_NOT_ALLOCATED = 2'd2,
        STAT_FULL          = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   block_index;
        logic [REM_W-1:0]     remaining_size;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> hdl/best_fit_block_allocator.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ---------------------------------------
// in        sink       i_in_valid / o_in_stall   i_func, i_size_value
// out       source     o_out_valid / i_out_stall o_status, o_block_index, o_remaining_size
//
// A load request goes from accept straight to its result step. An allocation
// request scans the loaded blocks, then finishes: the scan reads one stored
// block size per cycle through the single read port of the size table, then
// a drain step compares the last read and a finish step writes back the
// chosen entry. An allocation on an empty table skips the scan.
// Reset (synchronous, active low) empties the table; no clearing pass is run.
// One request is in work at a time; a new request is taken while the previous
// result still waits in the output register, and the write-back stalls until
// that register is free.

module best_fit_block_allocator #(
    parameter int MAX_BLOCKS = bfa_pkg::DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = bfa_pkg::DEF_SIZE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_func,
    input  wire logic [bfa_pkg::SIZE_IN_W-1:0] i_size_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [1:0]                    o_status,
    output logic      [bfa_pkg::INDEX_W-1:0]   o_block_index,
    output logic      [bfa_pkg::REM_W-1:0]     o_remaining_size
);

    import bfa_pkg::*;

    // Table address width and a block counter that can hold the capacity itself
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic                 busy;
    logic                 slot_free;
    logic                 res_vld;
    t_result              res;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    logic [SIZE_BITS-1:0] mem_rdata;
    logic                 r_out_vld;
    t_result              r_out;

    // The output register is free when empty or when its result leaves now
    assign slot_free  = !r_out_vld || !i_out_stall;
    // Hold off new requests while one is in work
    assign o_in_stall = busy;

    bfa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_busy       (busy),
        .i_func       (i_func),
        .i_size_value (i_size_value),
        .i_slot_free  (slot_free),
        .o_res_vld    (res_vld),
        .o_res        (res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    // Free block sizes, one entry per loaded block
    bfa_size_mem #(
        .DEPTH  (MAX_BLOCKS),
        .WIDTH  (SIZE_BITS),
        .ADDR_W (IDX_W)
    ) u_size_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out.status;
    assign o_block_index    = r_out.block_index;
    assign o_remaining_size = r_out.remaining_size;

endmodule

`default_nettype wire

>>> hdl/bfa_size_mem.sv
`default_nettype none

module bfa_size_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/bfa_ctrl.sv
`default_nettype none

module bfa_ctrl #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_busy,
    input  wire logic                          i_func,
    input  wire logic [bfa_pkg::SIZE_IN_W-1:0] i_size_value,
    input  wire logic                          i_slot_free,
    output logic                               o_res_vld,
    output bfa_pkg::t_result                   o_res,
    output logic                               o_mem_we,
    output logic      [IDX_W-1:0]              o_mem_waddr,
    output logic      [SIZE_BITS-1:0]          o_mem_wdata,
    output logic                               o_mem_re,
    output logic      [IDX_W-1:0]              o_mem_raddr,
    input  wire logic [SIZE_BITS-1:0]          i_mem_rdata
);

    import bfa_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic                 r_func;
    logic [SIZE_BITS-1:0] r_req;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_addr;
    logic [CNT_W-1:0]     n_addr;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [SIZE_BITS-1:0] r_best_size;
    logic                 full;
    logic                 better;
    logic [SIZE_BITS-1:0] left;

    assign full   = (r_count == CNT_W'(MAX_BLOCKS));
    assign n_addr = r_addr + CNT_W'(1);
    assign left   = r_best_size - r_req;
    assign better = r_cmp_vld && (i_mem_rdata >= r_req)
                    && (!r_found || (i_mem_rdata < r_best_size));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_LOAD || r_count == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (n_addr == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_busy      = 1'b1;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_addr[IDX_W-1:0];
        o_mem_we    = 1'b0;
        o_mem_waddr = r_count[IDX_W-1:0];
        o_mem_wdata = r_req;
        o_res_vld   = 1'b0;
        o_res       = '{status: STAT_NOT_ALLOCATED, block_index: '0, remaining_size: '0};
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
            end
            S_SCAN: begin
                o_mem_re = 1'b1;
            end
            S_DRAIN: begin
                o_mem_re = 1'b0;
            end
            S_FINISH: begin
                o_res_vld = i_slot_free;
                if (r_func == FUNC_LOAD) begin
                    if (full) begin
                        o_res.status = STAT_FULL;
                    end else begin
                        o_res.status      = STAT_LOADED;
                        o_res.block_index = INDEX_W'(r_count);
                        o_mem_we          = i_slot_free;
                    end
                end else if (r_found) begin
                    o_res.status         = STAT_ALLOCATED;
                    o_res.block_index    = INDEX_W'(r_best_idx);
                    o_res.remaining_size = REM_W'(left);
                    o_mem_we             = i_slot_free;
                    o_mem_waddr          = r_best_idx;
                    o_mem_wdata          = left;
                end
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in_valid) begin
                r_found   <= 1'b0;
                r_cmp_vld <= 1'b0;
            end else begin
                r_cmp_vld <= (r_state == S_SCAN);
                if (better) begin
                    r_found <= 1'b1;
                end
            end
            if (r_state == S_FINISH && i_slot_free && r_func == FUNC_LOAD && !full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_func <= i_func;
            r_req  <= SIZE_BITS'(i_size_value);
            r_addr <= '0;
        end else if (r_state == S_SCAN) begin
            r_addr <= n_addr;
        end
        r_cmp_idx <= r_addr[IDX_W-1:0];
        if (better) begin
            r_best_idx  <= r_cmp_idx;
            r_best_size <= i_mem_rdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count above capacity");

    a_write_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == S_FINISH && i_slot_free))
        else $error("table write outside finish step");

    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && r_state != S_IDLE) |-> (r_best_size >= r_req))
        else $error("chosen block smaller than request");

    a_count_moves_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count))
            |-> ($past(r_state) == S_FINISH && $past(r_func) == FUNC_LOAD))
        else $error("block count changed outside a load");

endmodule

`default_nettype wire
